>>> sv/b58_pkg.sv
// ----------------------------------------------------------------------------
// b58_pkg: shared constants, types and functions of the base58 encoder
// Sizes of the digit store and counters, the alphabet table, the reciprocal
// used for the divide by 58, and the controller state type.
// ----------------------------------------------------------------------------
package b58_pkg;

    // message and digit store sizes
    localparam int MAX_BYTES   = 32;
    localparam int DIGIT_SLOTS = 45;
    localparam int MAX_RESULTS = 45;
    localparam int RADIX       = 58;

    // field and counter widths
    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 6;
    localparam int IDX_W   = $clog2(DIGIT_SLOTS);
    localparam int SPAN_W  = $clog2(DIGIT_SLOTS + 1);
    localparam int CNT_W   = $clog2(MAX_BYTES + 1);
    localparam int RES_W   = $clog2(MAX_RESULTS + 1);
    localparam int SUM_W   = ((CNT_W > SPAN_W) ? CNT_W : SPAN_W) + 1;

    // digit * 256 + carry, and its quotient by 58 through a reciprocal:
    // q = (t * 1130) >> 16 is exact for every t below 58 * 256
    localparam int FOLD_W      = DIGIT_W + BYTE_W;
    localparam int RECIP       = 1130;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = RECIP_SHIFT + BYTE_W + 1;

    // alphabet, first character in the top byte
    localparam logic [8*RADIX-1:0] ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    localparam logic [BYTE_W-1:0] ZERO_SYMBOL = ALPHABET[8*RADIX-1 -: 8];

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_SETUP,
        S_EMIT,
        S_EMITD
    } t_state;

    // character for one base-58 digit; codes past the radix map to zero
    function automatic logic [BYTE_W-1:0] alpha_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] dd;
        dd = (d >= DIGIT_W'(RADIX)) ? '0 : d;
        return ALPHABET[8*(RADIX-1-int'(dd)) +: 8];
    endfunction

endpackage

>>> sv/b58_if.sv
// ----------------------------------------------------------------------------
// b58_if: word channels of the base58 encoder
// Valid/ready channels for the message bytes and for the encoded characters.
// ----------------------------------------------------------------------------
interface b58_in_if;
    logic                        valid;
    logic                        ready;
    logic [b58_pkg::BYTE_W-1:0]  data_byte;
    logic                        final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface b58_out_if;
    logic                        valid;
    logic                        ready;
    logic [b58_pkg::BYTE_W-1:0]  symbol;
    logic                        end_of_text;

    modport source (output valid, output symbol, output end_of_text, input ready);
    modport sink   (input valid, input symbol, input end_of_text, output ready);
endinterface

>>> sv/base58_encoder.sv
// ----------------------------------------------------------------------------
// base58_encoder: streaming base58 encoder, Bitcoin alphabet
// Folds message bytes into a base-58 digit store, then emits the encoding.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte takes one message byte per word, most significant first; the
//   word with final_byte set ends the message. o_sym gives one ASCII
//   character per word, end_of_text on the last one. A '1' comes out for
//   each leading zero byte, then the digits, most significant first.
// Operation:
//   Each byte ripples its carry through the digit memory one digit per
//   cycle over its single read and write port; i_byte.ready is low
//   meanwhile. After the final byte is handled, a setup state follows;
//   each leading '1' is then output directly, and each digit is read
//   from memory, then output. Bytes past MAX_BYTES are taken but not
//   folded in.
// Reset and stall:
//   Reset empties the message state and the output register. No memory
//   clearing is needed: entries above the used span read as zero. When
//   the receiver stalls, the character holds in the output register and
//   the encoder waits; the next message can be taken as soon as the last
//   character sits in the output register.
// ----------------------------------------------------------------------------
module base58_encoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    b58_in_if.sink    i_byte,
    b58_out_if.source o_sym
);

    // digit store, least significant digit at address 0
    logic [b58_pkg::DIGIT_W-1:0] r_mem [b58_pkg::DIGIT_SLOTS];
    logic [b58_pkg::DIGIT_W-1:0] r_rd;

    b58_pkg::t_state r_state, n_state;

    logic [b58_pkg::BYTE_W-1:0]  r_carry,   n_carry;
    logic [b58_pkg::SPAN_W-1:0]  r_idx,     n_idx;
    logic [b58_pkg::SPAN_W-1:0]  r_last_nz, n_last_nz;
    logic [b58_pkg::SPAN_W-1:0]  r_span,    n_span;
    logic [b58_pkg::SPAN_W-1:0]  r_didx,    n_didx;
    logic [b58_pkg::CNT_W-1:0]   r_lz,      n_lz;
    logic [b58_pkg::CNT_W-1:0]   r_taken,   n_taken;
    logic                        r_nz,      n_nz;
    logic                        r_fin,     n_fin;
    logic [b58_pkg::RES_W-1:0]   r_k,       n_k;
    logic [b58_pkg::RES_W-1:0]   r_total,   n_total;
    logic                        r_ovalid,  n_ovalid;
    logic [b58_pkg::BYTE_W-1:0]  r_sym,     n_sym;
    logic                        r_eot,     n_eot;

    logic                         w_accept;
    logic                         w_out_free;
    logic                         w_fold_stop;
    logic                         w_in_range;
    logic                         w_is_lead;
    logic                         w_last;
    logic [b58_pkg::DIGIT_W-1:0]  w_digit;
    logic [b58_pkg::FOLD_W-1:0]   w_t;
    logic [b58_pkg::PROD_W-1:0]   w_prod;
    logic [b58_pkg::BYTE_W-1:0]   w_q;
    logic [b58_pkg::FOLD_W-1:0]   w_rem_full;
    logic [b58_pkg::DIGIT_W-1:0]  w_rem;
    logic [b58_pkg::SPAN_W-1:0]   w_rd_addr;
    logic                         w_we;
    logic [b58_pkg::SUM_W-1:0]    w_lz_eff;
    logic [b58_pkg::SUM_W-1:0]    w_sum;
    logic [b58_pkg::RES_W-1:0]    w_k_next;

    assign w_accept   = i_byte.valid && i_byte.ready;
    assign w_out_free = !r_ovalid || o_sym.ready;

    // one fold step: digit * 256 + carry, split by 58
    assign w_in_range  = (r_idx < r_span);
    assign w_digit     = w_in_range ? r_rd : '0;
    assign w_fold_stop = (!w_in_range && (r_carry == '0))
                      || (r_idx == b58_pkg::SPAN_W'(b58_pkg::DIGIT_SLOTS));
    assign w_t         = {w_digit, r_carry};
    assign w_prod      = b58_pkg::PROD_W'(w_t) * b58_pkg::PROD_W'(b58_pkg::RECIP);
    assign w_q         = w_prod[b58_pkg::RECIP_SHIFT +: b58_pkg::BYTE_W];
    // q * 58 = q*64 - q*4 - q*2
    assign w_rem_full  = w_t - ({w_q, 6'b0}
                               - b58_pkg::FOLD_W'({w_q, 2'b0})
                               - b58_pkg::FOLD_W'({w_q, 1'b0}));
    assign w_rem       = w_rem_full[b58_pkg::DIGIT_W-1:0];

    // emit bookkeeping
    assign w_k_next  = r_k + 1'b1;
    assign w_last    = (w_k_next == r_total);
    assign w_is_lead = (b58_pkg::SUM_W'(r_k) < b58_pkg::SUM_W'(r_lz));
    assign w_lz_eff  = ((r_lz == '0) && (r_span == '0)) ? b58_pkg::SUM_W'(1)
                                                         : b58_pkg::SUM_W'(r_lz);
    assign w_sum     = w_lz_eff + b58_pkg::SUM_W'(r_span);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            b58_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (r_taken < b58_pkg::CNT_W'(b58_pkg::MAX_BYTES)) begin
                        n_state = b58_pkg::S_FOLD;
                    end else if (i_byte.final_byte) begin
                        n_state = b58_pkg::S_SETUP;
                    end
                end
            end
            b58_pkg::S_FOLD: begin
                if (w_fold_stop) begin
                    n_state = r_fin ? b58_pkg::S_SETUP : b58_pkg::S_IDLE;
                end
            end
            b58_pkg::S_SETUP: begin
                n_state = b58_pkg::S_EMIT;
            end
            b58_pkg::S_EMIT: begin
                if (w_is_lead) begin
                    if (w_out_free && w_last) begin
                        n_state = b58_pkg::S_IDLE;
                    end
                end else begin
                    n_state = b58_pkg::S_EMITD;
                end
            end
            b58_pkg::S_EMITD: begin
                if (w_out_free) begin
                    n_state = w_last ? b58_pkg::S_IDLE : b58_pkg::S_EMIT;
                end
            end
            default: begin
                n_state = b58_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_carry   = r_carry;
        n_idx     = r_idx;
        n_last_nz = r_last_nz;
        n_span    = r_span;
        n_didx    = r_didx;
        n_lz      = r_lz;
        n_taken   = r_taken;
        n_nz      = r_nz;
        n_fin     = r_fin;
        n_k       = r_k;
        n_total   = r_total;
        n_ovalid  = r_ovalid && !o_sym.ready;
        n_sym     = r_sym;
        n_eot     = r_eot;
        w_rd_addr = r_idx + 1'b1;
        w_we      = 1'b0;
        case (r_state)
            b58_pkg::S_IDLE: begin
                w_rd_addr = '0;
                if (w_accept) begin
                    n_fin     = i_byte.final_byte;
                    n_carry   = i_byte.data_byte;
                    n_idx     = '0;
                    n_last_nz = '0;
                    if (r_taken < b58_pkg::CNT_W'(b58_pkg::MAX_BYTES)) begin
                        n_taken = r_taken + 1'b1;
                        if (i_byte.data_byte != '0) begin
                            n_nz = 1'b1;
                        end else if (!r_nz) begin
                            n_lz = r_lz + 1'b1;
                        end
                    end
                end
            end
            b58_pkg::S_FOLD: begin
                if (w_fold_stop) begin
                    if (!w_in_range) begin
                        n_span = r_last_nz;
                    end
                end else begin
                    w_we    = 1'b1;
                    n_carry = w_q;
                    n_idx   = r_idx + 1'b1;
                    if (w_rem != '0) begin
                        n_last_nz = r_idx + 1'b1;
                    end
                end
            end
            b58_pkg::S_SETUP: begin
                n_k    = '0;
                n_didx = r_span - 1'b1;
                n_lz   = b58_pkg::CNT_W'(w_lz_eff);
                if (w_sum > b58_pkg::SUM_W'(b58_pkg::MAX_RESULTS)) begin
                    n_total = b58_pkg::RES_W'(b58_pkg::MAX_RESULTS);
                end else begin
                    n_total = b58_pkg::RES_W'(w_sum);
                end
            end
            b58_pkg::S_EMIT: begin
                w_rd_addr = r_didx;
                if (w_is_lead && w_out_free) begin
                    n_ovalid = 1'b1;
                    n_sym    = b58_pkg::ZERO_SYMBOL;
                    n_eot    = w_last;
                    n_k      = w_k_next;
                end
            end
            b58_pkg::S_EMITD: begin
                w_rd_addr = r_didx;
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_sym    = b58_pkg::alpha_char(r_rd);
                    n_eot    = w_last;
                    n_k      = w_k_next;
                    n_didx   = r_didx - 1'b1;
                end
            end
            default: begin
                w_rd_addr = '0;
            end
        endcase
        // message done: drop its state
        if ((r_state == b58_pkg::S_EMIT || r_state == b58_pkg::S_EMITD)
                && n_state == b58_pkg::S_IDLE) begin
            n_span  = '0;
            n_lz    = '0;
            n_nz    = 1'b0;
            n_taken = '0;
        end
    end

    // digit memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx[b58_pkg::IDX_W-1:0]] <= w_rem;
        end
        if (w_rd_addr < b58_pkg::SPAN_W'(b58_pkg::DIGIT_SLOTS)) begin
            r_rd <= r_mem[w_rd_addr[b58_pkg::IDX_W-1:0]];
        end else begin
            r_rd <= '0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= b58_pkg::S_IDLE;
            r_span   <= '0;
            r_lz     <= '0;
            r_taken  <= '0;
            r_nz     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_span   <= n_span;
            r_lz     <= n_lz;
            r_taken  <= n_taken;
            r_nz     <= n_nz;
            r_ovalid <= n_ovalid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_carry   <= n_carry;
        r_idx     <= n_idx;
        r_last_nz <= n_last_nz;
        r_didx    <= n_didx;
        r_fin     <= n_fin;
        r_k       <= n_k;
        r_total   <= n_total;
        r_sym     <= n_sym;
        r_eot     <= n_eot;
    end

    assign i_byte.ready      = (r_state == b58_pkg::S_IDLE);
    assign o_sym.valid       = r_ovalid;
    assign o_sym.symbol      = r_sym;
    assign o_sym.end_of_text = r_eot;

endmodule

>>> sv/b58_checker.sv
// ----------------------------------------------------------------------------
// b58_checker: port-level checks of the base58 encoder
// Watches both channels and flags stalls that drop data, characters outside
// the alphabet, input taken in the middle of an encoding and characters from non-final bytes.
// ----------------------------------------------------------------------------
module b58_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_final,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [b58_pkg::BYTE_W-1:0]  i_out_symbol,
    input logic                        i_out_eot
);

    // stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_symbol) && $stable(i_out_eot))
        else $error("output word changed while stalled");

    // characters are base58 alphabet only ('1'-'9','A'-'H','J'-'N','P'-'Z','a'-'k','m'-'z')
    a_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |->
            (i_out_symbol >= 8'd49  && i_out_symbol <= 8'd57)
         || (i_out_symbol >= 8'd65  && i_out_symbol <= 8'd72)
         || (i_out_symbol >= 8'd74  && i_out_symbol <= 8'd78)
         || (i_out_symbol >= 8'd80  && i_out_symbol <= 8'd90)
         || (i_out_symbol >= 8'd97  && i_out_symbol <= 8'd107)
         || (i_out_symbol >= 8'd109 && i_out_symbol <= 8'd122))
        else $error("symbol outside the base58 alphabet");

    // no byte taken while an encoding is still going out
    a_no_input_mid_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_eot |-> !i_in_ready)
        else $error("input ready in the middle of an encoding");

    // a byte without the final flag produces no character
    a_quiet_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_final && !i_out_valid |=> !i_out_valid)
        else $error("character produced by a non-final byte");

endmodule

bind base58_encoder b58_checker u_b58_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_byte.valid),
    .i_in_ready   (i_byte.ready),
    .i_in_final   (i_byte.final_byte),
    .i_out_valid  (o_sym.valid),
    .i_out_ready  (o_sym.ready),
    .i_out_symbol (o_sym.symbol),
    .i_out_eot    (o_sym.end_of_text)
);
